FILE: rtl/palette_gradient_color_map_top_macros.svh
// assertion macros used by the checker file
`ifndef PALETTE_GRADIENT_COLOR_MAP_TOP_MACROS_SVH
`define PALETTE_GRADIENT_COLOR_MAP_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PGCM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pgcm_pkg.sv
`default_nettype none

package pgcm_pkg;

    // operation codes of an input word
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PALETTE_SELECT = 2'd0,
        REG_USER_COUNT     = 2'd1,
        REG_OUTPUT_SCALE   = 2'd2
    } cfg_reg_t;

    // palette selector codes
    localparam logic [2:0] PAL_GRAY = 3'd5;
    localparam logic [2:0] PAL_USER = 3'd6;
    localparam logic [2:0] PAL_SPARE = 3'd7;

    // stage advance strobes handed to the channel datapath
    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
    } pgcm_adv_t;

    // built-in palettes, packed back to back
    localparam int ROM_ENTRIES = 47;
    localparam logic [23:0] ROM_COLORS [ROM_ENTRIES] = '{
        // green-yellow-red
        24'h00ff00, 24'hff0000,
        // red-yellow-green
        24'hff0000, 24'h00ff00,
        // rainbow
        24'hff00ff, 24'h0000ff, 24'h00ffff, 24'h00ff00, 24'hffff00, 24'hff0000,
        // blue-pink-yellow
        24'h000066, 24'h0000a3, 24'h0000e1, 24'h1900ff, 24'h4900ff, 24'h7a00ff,
        24'haa16e8, 24'hdb35c9, 24'hff54aa, 24'hff738b, 24'hff926c, 24'hffb14d,
        24'hffd02e, 24'hffef0f, 24'hffff5f,
        // green-yellow-red fine
        24'h197f00, 24'h339900, 24'h59ad00, 24'h7fbf00, 24'h99cc00, 24'hb2d800,
        24'hd8ed00, 24'hf2ff00, 24'hfad600, 24'hffbf00, 24'hffa800, 24'hff7f00,
        24'hff6600, 24'hff5400, 24'hff0000,
        // gray
        24'hacacac, 24'h8c8c8c, 24'h6c6c6c, 24'h4c4c4c, 24'h323232, 24'h191919,
        24'h0a0a0a
    };
    localparam logic [5:0] ROM_START [6] = '{6'd0, 6'd2, 6'd4, 6'd10, 6'd25, 6'd40};
    localparam logic [4:0] ROM_LEN   [6] = '{5'd2, 5'd2, 5'd6, 5'd15, 5'd15, 5'd7};

    // built-in palette entry, selector and index clamped into the table
    function automatic logic [23:0] rom_color(input logic [2:0] sel, input logic [4:0] k);
        logic [2:0] s;
        logic [4:0] kk;
        logic [5:0] addr;
        s = (sel > PAL_GRAY) ? PAL_GRAY : sel;
        kk = (k >= ROM_LEN[s]) ? (ROM_LEN[s] - 5'd1) : k;
        addr = ROM_START[s] + {1'b0, kk};
        return ROM_COLORS[addr];
    endfunction

    // entry count minus one of a built-in palette
    function automatic logic [4:0] rom_last(input logic [2:0] sel);
        logic [2:0] s;
        s = (sel > PAL_GRAY) ? PAL_GRAY : sel;
        return ROM_LEN[s] - 5'd1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pgcm_channel.sv
`default_nettype none

module pgcm_channel
    import pgcm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire pgcm_adv_t            adv,
    input  wire logic [7:0]           lo_level,
    input  wire logic [7:0]           hi_level,
    input  wire logic [FRAC_BITS-1:0] frac,
    input  wire logic [15:0]          scale,
    output logic      [23:0]          level
);

    localparam logic [FRAC_BITS:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    // floor(y / 255) = (y * RECIP_255) >> 39 for any 32-bit y
    localparam logic [63:0] RECIP_255 = 64'h0000_0000_8080_8081;

    logic [FRAC_BITS:0]    w_hi;
    logic [FRAC_BITS:0]    w_lo;
    logic [FRAC_BITS+8:0]  blend;
    logic [FRAC_BITS+7:0]  weighted_reg;
    logic [FRAC_BITS+23:0] scaled;
    logic [31:0]           scaled_reg;
    logic [63:0]           recip_prod;
    logic [23:0]           level_reg;

    // interpolation weights and blend of the two neighbor levels
    always_comb
    begin
        w_hi = {1'b0, frac};
        w_lo = POS_ONE - w_hi;
        blend = (FRAC_BITS+9)'(lo_level) * (FRAC_BITS+9)'(w_lo)
              + (FRAC_BITS+9)'(hi_level) * (FRAC_BITS+9)'(w_hi);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            weighted_reg <= blend[FRAC_BITS+7:0];
        end
    end

    // scale by output range, keep 8 fraction bits of the level
    assign scaled = (FRAC_BITS+24)'(weighted_reg) * (FRAC_BITS+24)'(scale);

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            scaled_reg <= scaled[FRAC_BITS+23:FRAC_BITS-8];
        end
    end

    // divide by 255 through the reciprocal
    assign recip_prod = 64'(scaled_reg) * RECIP_255;

    always_ff @(posedge clk)
    begin
        if (adv.s6)
        begin
            level_reg <= recip_prod[62:39];
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

FILE: rtl/palette_gradient_color_map_top.sv
// Palette color ramp: maps a position in [0,1] to an RGB color.
// Input channel: in_valid / in_stall with operation, position, entry_index and
// entry_color. A lookup word returns the interpolated color; a write word
// stores entry_color in the user palette and returns an all-zero word.
// Output channel: out_valid / out_stall with red, green, blue (Q.8) and
// out_of_range. One output word per input word, in order.
// One word is taken every cycle while out_stall is low. The six stages are:
// clamp, position multiply, palette read, blend, output scaling, divide by
// 255 through a reciprocal multiply.
// When out_stall is high the pipeline keeps moving until its bubbles are
// filled, then in_stall rises; nothing is dropped or repeated.
// Configuration: cfg_write_en / cfg_index / cfg_data, written while idle.
// Reset clears all valid bits and sets palette 0, user count 2 and output
// scale 255. User palette entries are undefined until written.
`default_nettype none

module palette_gradient_color_map_top
    import pgcm_pkg::*;
#(
    parameter int USER_DEPTH = 16,
    parameter int POSITION_FRACTION_BITS = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            cfg_write_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [15:0]                     cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [POSITION_FRACTION_BITS:0] position,
    input  wire logic [3:0]                      entry_index,
    input  wire logic [23:0]                     entry_color,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [23:0]                     red,
    output logic      [23:0]                     green,
    output logic      [23:0]                     blue,
    output logic                                 out_of_range
);

    localparam int F  = POSITION_FRACTION_BITS;
    localparam int IW = $clog2(USER_DEPTH);
    localparam logic [F:0] POS_ONE = {1'b1, {F{1'b0}}};

    // configuration registers
    logic [2:0]  palette_select_reg;
    logic [4:0]  user_count_reg;
    logic [15:0] output_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_select_reg <= 3'd0;
            user_count_reg     <= 5'd2;
            output_scale_reg   <= 16'd255;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PALETTE_SELECT: palette_select_reg <= cfg_data[2:0];
                REG_USER_COUNT:     user_count_reg     <= cfg_data[4:0];
                REG_OUTPUT_SCALE:   output_scale_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic ready1, ready2, ready3, ready4, ready5, ready6;

    always_comb
    begin
        ready6 = !v6_reg || !out_stall;
        ready5 = !v5_reg || ready6;
        ready4 = !v4_reg || ready5;
        ready3 = !v3_reg || ready4;
        ready2 = !v2_reg || ready3;
        ready1 = !v1_reg || ready2;
    end

    assign in_stall  = !ready1;
    assign out_valid = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= in_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
            if (ready5) v5_reg <= v4_reg;
            if (ready6) v6_reg <= v5_reg;
        end
    end

    // stage 1: clamp position, fold selector, entry count minus one
    logic       over_one;
    logic [2:0] sel_fold;
    logic [4:0] last_idx;

    logic          op1_reg;
    logic [F:0]    pos1_reg;
    logic          oor1_reg;
    logic [3:0]    idx1_reg;
    logic [23:0]   color1_reg;
    logic [2:0]    sel1_reg;
    logic [4:0]    last1_reg;

    always_comb
    begin
        over_one = position > POS_ONE;
        sel_fold = (palette_select_reg == PAL_SPARE) ? PAL_GRAY : palette_select_reg;
        if (sel_fold == PAL_USER)
        begin
            if (32'(user_count_reg) > USER_DEPTH)
                last_idx = 5'(USER_DEPTH - 1);
            else if (user_count_reg < 5'd2)
                last_idx = 5'd1;
            else
                last_idx = user_count_reg - 5'd1;
        end
        else
        begin
            last_idx = rom_last(sel_fold);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            op1_reg    <= operation;
            pos1_reg   <= over_one ? POS_ONE : position;
            oor1_reg   <= over_one && (operation == OP_LOOKUP);
            idx1_reg   <= entry_index;
            color1_reg <= entry_color;
            sel1_reg   <= sel_fold;
            last1_reg  <= last_idx;
        end
    end

    // stage 2: scale position by entry count minus one
    logic [F+5:0] t_prod;

    logic          op2_reg;
    logic          oor2_reg;
    logic [3:0]    idx2_reg;
    logic [23:0]   color2_reg;
    logic [2:0]    sel2_reg;
    logic [4:0]    lo2_reg;
    logic [F-1:0]  frac2_reg;

    assign t_prod = (F+6)'(pos1_reg) * (F+6)'(last1_reg);

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            op2_reg    <= op1_reg;
            oor2_reg   <= oor1_reg;
            idx2_reg   <= idx1_reg;
            color2_reg <= color1_reg;
            sel2_reg   <= sel1_reg;
            lo2_reg    <= t_prod[F+4:F];
            frac2_reg  <= t_prod[F-1:0];
        end
    end

    // stage 3: read both neighbor entries, user palette writes land here too
    logic [4:0]    hi_idx;
    logic [IW+4:0] lo_ext;
    logic [IW+4:0] hi_ext;
    logic [IW+3:0] wr_ext;
    logic [IW-1:0] lo_addr;
    logic [IW-1:0] hi_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    logic [23:0]   user_mem [USER_DEPTH];
    logic [23:0]   lo_mem3_reg;
    logic [23:0]   hi_mem3_reg;
    logic [23:0]   lo_rom3_reg;
    logic [23:0]   hi_rom3_reg;
    logic          user3_reg;
    logic          op3_reg;
    logic          oor3_reg;
    logic [F-1:0]  frac3_reg;

    always_comb
    begin
        hi_idx  = (frac2_reg != '0) ? (lo2_reg + 5'd1) : lo2_reg;
        lo_ext  = {{IW{1'b0}}, lo2_reg};
        hi_ext  = {{IW{1'b0}}, hi_idx};
        wr_ext  = {{IW{1'b0}}, idx2_reg};
        lo_addr = lo_ext[IW-1:0];
        hi_addr = hi_ext[IW-1:0];
        wr_addr = wr_ext[IW-1:0];
        wr_en   = ready3 && v2_reg && (op2_reg == OP_WRITE)
               && (32'(idx2_reg) < USER_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            user_mem[wr_addr] <= color2_reg;
        end
        if (ready3)
        begin
            lo_mem3_reg <= user_mem[lo_addr];
            hi_mem3_reg <= user_mem[hi_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            lo_rom3_reg <= rom_color(sel2_reg, lo2_reg);
            hi_rom3_reg <= rom_color(sel2_reg, hi_idx);
            user3_reg   <= (sel2_reg == PAL_USER);
            op3_reg     <= op2_reg;
            oor3_reg    <= oor2_reg;
            frac3_reg   <= frac2_reg;
        end
    end

    // stages 4 to 6: per-channel blend, scaling and divide
    logic [23:0] lo_col;
    logic [23:0] hi_col;
    pgcm_adv_t   adv;

    always_comb
    begin
        lo_col = user3_reg ? lo_mem3_reg : lo_rom3_reg;
        hi_col = user3_reg ? hi_mem3_reg : hi_rom3_reg;
        if (op3_reg == OP_WRITE)
        begin
            lo_col = '0;
            hi_col = '0;
        end
        adv.s4 = ready4;
        adv.s5 = ready5;
        adv.s6 = ready6;
    end

    pgcm_channel #(.FRAC_BITS(F)) u_red
    (
        .clk      (clk),
        .adv      (adv),
        .lo_level (lo_col[23:16]),
        .hi_level (hi_col[23:16]),
        .frac     (frac3_reg),
        .scale    (output_scale_reg),
        .level    (red)
    );

    pgcm_channel #(.FRAC_BITS(F)) u_green
    (
        .clk      (clk),
        .adv      (adv),
        .lo_level (lo_col[15:8]),
        .hi_level (hi_col[15:8]),
        .frac     (frac3_reg),
        .scale    (output_scale_reg),
        .level    (green)
    );

    pgcm_channel #(.FRAC_BITS(F)) u_blue
    (
        .clk      (clk),
        .adv      (adv),
        .lo_level (lo_col[7:0]),
        .hi_level (hi_col[7:0]),
        .frac     (frac3_reg),
        .scale    (output_scale_reg),
        .level    (blue)
    );

    // range flag follows the channel stages
    logic oor4_reg, oor5_reg, oor6_reg;

    always_ff @(posedge clk)
    begin
        if (ready4) oor4_reg <= oor3_reg;
        if (ready5) oor5_reg <= oor4_reg;
        if (ready6) oor6_reg <= oor5_reg;
    end

    assign out_of_range = oor6_reg;

endmodule

`default_nettype wire

FILE: rtl/pgcm_checker.sv
`default_nettype none

`include "palette_gradient_color_map_top_macros.svh"

module pgcm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [23:0] red,
    input wire logic [23:0] green,
    input wire logic [23:0] blue,
    input wire logic        out_of_range
);

    localparam logic [3:0] PIPE_DEPTH = 4'd6;
    localparam logic [23:0] LEVEL_MAX = 24'hffff00;

    // words accepted but not yet delivered
    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       in_take;
    logic       out_take;

    always_comb
    begin
        in_take  = in_valid && !in_stall;
        out_take = out_valid && !out_stall;
        pend_next = pend_reg + {3'd0, in_take} - {3'd0, out_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 4'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `PGCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(out_of_range), "output word changed while stalled")
    `PGCM_ASSERT_IMPL(a_no_invented, out_valid, pend_reg != 4'd0, "output word without a pending input word")
    `PGCM_ASSERT_IMPL(a_depth, 1'b1, pend_reg <= PIPE_DEPTH, "more words in flight than pipeline stages")
    `PGCM_ASSERT_IMPL(a_flow, !out_stall, !in_stall, "input stalled while output flows")
    `PGCM_ASSERT_IMPL(a_level_max, out_valid, red <= LEVEL_MAX && green <= LEVEL_MAX && blue <= LEVEL_MAX, "channel level above full scale")

endmodule

bind palette_gradient_color_map_top pgcm_checker u_pgcm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_of_range (out_of_range)
);

`default_nettype wire

FILE: tb/palette_gradient_color_map_top_tb.sv
module palette_gradient_color_map_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgcm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [16:0] POS_ONE = 17'h10000;
    localparam logic [2:0] PAL_GREEN_RED = 3'd0;

    // built-in color ramps, back to back
    localparam logic [23:0] RAMP_RGB [47] = '{
        24'h00ff00, 24'hff0000,
        24'hff0000, 24'h00ff00,
        24'hff00ff, 24'h0000ff, 24'h00ffff, 24'h00ff00, 24'hffff00, 24'hff0000,
        24'h000066, 24'h0000a3, 24'h0000e1, 24'h1900ff, 24'h4900ff, 24'h7a00ff,
        24'haa16e8, 24'hdb35c9, 24'hff54aa, 24'hff738b, 24'hff926c, 24'hffb14d,
        24'hffd02e, 24'hffef0f, 24'hffff5f,
        24'h197f00, 24'h339900, 24'h59ad00, 24'h7fbf00, 24'h99cc00, 24'hb2d800,
        24'hd8ed00, 24'hf2ff00, 24'hfad600, 24'hffbf00, 24'hffa800, 24'hff7f00,
        24'hff6600, 24'hff5400, 24'hff0000,
        24'hacacac, 24'h8c8c8c, 24'h6c6c6c, 24'h4c4c4c, 24'h323232, 24'h191919,
        24'h0a0a0a
    };
    localparam int RAMP_START [6] = '{0, 2, 4, 10, 25, 40};
    localparam int RAMP_LEN [6] = '{2, 2, 6, 15, 15, 7};

    typedef struct packed {
        logic        op;
        logic [16:0] pos;
        logic [3:0]  idx;
        logic [23:0] rgb;
    } input_word_t;

    typedef struct packed {
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
        logic        out_of_range;
    } color_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [16:0] position = '0;
    logic [3:0]  entry_index = '0;
    logic [23:0] entry_color = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
    logic        out_of_range;

    // shadow of the block's settings and user palette
    logic [2:0]  ramp_sel = 3'd0;
    logic [4:0]  ramp_count = 5'd2;
    logic [15:0] ramp_scale = 16'd255;
    logic [23:0] user_colors [16];

    input_word_t stim_words [$];
    color_word_t pending_colors [$];
    input_word_t stim_head;
    color_word_t want;

    int  errors = 0;
    int  cycle_count = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  idling = 1'b0;
    int  lookups_seen = 0;
    int  clamped_seen = 0;
    int  writes_seen = 0;
    int  settings_seen = 0;

    palette_gradient_color_map_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .position     (position),
        .entry_index  (entry_index),
        .entry_color  (entry_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_of_range (out_of_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // palette entry k of ramp s, index clamped for built-in ramps
    function automatic logic [23:0] palette_entry(input logic [2:0] s, input int k);
        int last;
        if (s == PAL_USER)
            return user_colors[k];
        last = RAMP_LEN[s] - 1;
        return RAMP_RGB[RAMP_START[s] + ((k > last) ? last : k)];
    endfunction

    // interpolated and scaled color at a position, current settings
    function automatic color_word_t ramp_color(input logic [16:0] pos_in);
        color_word_t res;
        logic [2:0]  s;
        int          n;
        int          lo;
        logic [16:0] p;
        logic [63:0] t;
        logic [63:0] w;
        logic [63:0] num;
        logic [63:0] frac;
        logic [23:0] c_lo;
        logic [23:0] c_hi;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [23:0] chan [3];
        s = (ramp_sel == PAL_SPARE) ? PAL_GRAY : ramp_sel;
        if (s == PAL_USER)
            n = (ramp_count < 2) ? 2 : ((ramp_count > 16) ? 16 : int'(ramp_count));
        else
            n = RAMP_LEN[s];
        res.out_of_range = (pos_in > POS_ONE);
        p = res.out_of_range ? POS_ONE : pos_in;
        if (p == POS_ONE)
        begin
            lo = n - 1;
            frac = 0;
        end
        else
        begin
            t = 64'(p) * 64'(n - 1);
            lo = int'(t >> 16);
            frac = t & 64'hffff;
        end
        c_lo = palette_entry(s, lo);
        c_hi = (frac != 0) ? palette_entry(s, lo + 1) : c_lo;
        for (int j = 0; j < 3; j++)
        begin
            a = 8'(c_lo >> (16 - 8 * j));
            b = 8'(c_hi >> (16 - 8 * j));
            w = 64'(a) * (64'(POS_ONE) - frac) + 64'(b) * frac;
            num = w * 64'(ramp_scale) * 64'd256;
            chan[j] = 24'(num / (64'd255 << 16));
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        return res;
    endfunction

    function automatic void add_lookup(input logic [16:0] pos);
        input_word_t wd;
        wd.op = OP_LOOKUP;
        wd.pos = pos;
        wd.idx = 4'($urandom);
        wd.rgb = 24'($urandom);
        stim_words.push_back(wd);
    endfunction

    function automatic void add_write(input logic [3:0] idx, input logic [23:0] rgb);
        input_word_t wd;
        wd.op = OP_WRITE;
        wd.pos = 17'($urandom);
        wd.idx = idx;
        wd.rgb = rgb;
        stim_words.push_back(wd);
    endfunction

    // mostly lookups spread over [0,1], some at the ends and beyond
    function automatic void add_random_word();
        logic [16:0] pos;
        if ($urandom_range(0, 3) == 0)
            add_write(4'($urandom), 24'($urandom));
        else
        begin
            case ($urandom_range(0, 19))
                0: pos = 17'd0;
                1: pos = POS_ONE;
                2: pos = 17'($urandom_range(32'h10001, 32'h1ffff));
                3: pos = POS_ONE - 17'd1;
                4: pos = 17'($urandom);
                default: pos = 17'($urandom_range(0, 32'hffff));
            endcase
            add_lookup(pos);
        end
    endfunction

    task automatic set_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_PALETTE_SELECT: ramp_sel = val[2:0];
            REG_USER_COUNT:     ramp_count = val[4:0];
            REG_OUTPUT_SCALE:   ramp_scale = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [2:0] sel, input logic [4:0] cnt,
                                 input logic [15:0] scale);
        set_reg(REG_PALETTE_SELECT, 16'(sel));
        set_reg(REG_USER_COUNT, 16'(cnt));
        set_reg(REG_OUTPUT_SCALE, scale);
        settings_seen++;
        @(negedge clk);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (stim_words.size() != 0 || in_valid || pending_colors.size() != 0);
    endtask

    // input driver: presents queued words, holds them while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == OP_WRITE)
                begin
                    user_colors[entry_index] = entry_color;
                    pending_colors.push_back('0);
                    writes_seen++;
                end
                else
                begin
                    pending_colors.push_back(ramp_color(position));
                    lookups_seen++;
                    if (position > POS_ONE)
                        clamped_seen++;
                end
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (idling && $urandom_range(0, 11) == 0)
                begin
                    in_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else if (stim_words.size() > 0)
                begin
                    stim_head = stim_words.pop_front();
                    in_valid <= 1'b1;
                    operation <= stim_head.op;
                    position <= stim_head.pos;
                    entry_index <= stim_head.idx;
                    entry_color <= stim_head.rgb;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor: compares each color word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_colors.size() == 0)
                begin
                    $error("color word with nothing pending");
                    errors++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (red !== want.red)
                    begin
                        $error("red: expected %h, got %h", want.red, red);
                        errors++;
                    end
                    if (green !== want.green)
                    begin
                        $error("green: expected %h, got %h", want.green, green);
                        errors++;
                    end
                    if (blue !== want.blue)
                    begin
                        $error("blue: expected %h, got %h", want.blue, blue);
                        errors++;
                    end
                    if (out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %b, got %b",
                               want.out_of_range, out_of_range);
                        errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (idling && $urandom_range(0, 11) == 0)
            begin
                out_gap = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[palette_gradient_color_map_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]  sel;
        logic [4:0]  cnt;
        logic [15:0] scale;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ends of the position range on the default ramp
        apply_setting(PAL_GREEN_RED, 5'd2, 16'd255);
        add_lookup(17'd0);
        add_lookup(17'd1);
        add_lookup(17'h08000);
        add_lookup(POS_ONE - 17'd1);
        add_lookup(POS_ONE);
        add_lookup(POS_ONE + 17'd1);
        add_lookup(17'h1ffff);
        // load every user entry so later user lookups are always defined
        add_write(4'd0, 24'hffffff);
        for (int k = 1; k < 15; k++)
            add_write(4'(k), 24'($urandom));
        add_write(4'd15, 24'h000000);
        drain();

        // directed: full user palette at the largest scale
        apply_setting(PAL_USER, 5'd16, 16'hffff);
        add_lookup(17'd0);
        add_lookup(17'h08000);
        add_lookup(POS_ONE);
        add_lookup(17'h1ffff);
        drain();

        // random settings, every selector first, then mostly user ramps
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph < 8)
                sel = 3'(ph);
            else
                sel = ($urandom_range(0, 2) != 0) ? PAL_USER : 3'($urandom);
            case (ph % 4)
                0: cnt = 5'($urandom_range(0, 1));
                1: cnt = 5'($urandom_range(17, 31));
                default: cnt = 5'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 5))
                0: scale = 16'd0;
                1: scale = 16'hffff;
                2: scale = 16'd255;
                3: scale = 16'd1;
                default: scale = 16'($urandom);
            endcase
            apply_setting(sel, cnt, scale);
            idling = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 32; i++)
                add_random_word();
            drain();
        end

        // closing stretch at full rate
        idling = 1'b0;
        apply_setting(PAL_USER, 5'd16, 16'hffff);
        for (int i = 0; i < 60; i++)
            add_random_word();
        drain();
        repeat (10) @(posedge clk);

        if (pending_colors.size() != 0)
        begin
            $error("%0d color words never arrived", pending_colors.size());
            errors++;
        end
        $display("run: %0d lookups (%0d past 1.0) and %0d palette writes",
                 lookups_seen, clamped_seen, writes_seen);
        $display("     over %0d register settings, every selector and count clamp",
                 settings_seen);
        if (errors == 0)
            $display("[palette_gradient_color_map_top] OK");
        else
            $display("[palette_gradient_color_map_top] ERROR");
        $finish;
    end

endmodule
